[rtl/modular_arith_barrett_unit_top_assert.svh]
// Assertion helpers for the modular arithmetic unit.
// Every helper samples on the rising edge of clock and is disabled while reset is high.
`ifndef MODULAR_ARITH_BARRETT_UNIT_TOP_ASSERT_SVH
`define MODULAR_ARITH_BARRETT_UNIT_TOP_ASSERT_SVH

// A condition that must hold at every clock edge.
`define MAB_ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define MAB_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// A consequence that must hold in the cycle after its antecedent.
`define MAB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/mab_pkg.sv]
`default_nettype none

package mab_pkg;

   // Field widths.
   localparam int RES_W      = 31;
   localparam int WIDE_W     = 64;
   localparam int CMD_W      = 3;
   localparam int RECIP_W    = 64;
   localparam int WORD_W     = 32;
   localparam int PROD_W     = 2 * RES_W;
   localparam int ZH_W       = PROD_W - WORD_W;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 64;

   // Remainder pipeline: dividend bits retired per stage.
   localparam int DIV_BITS    = 8;
   localparam int WIDE_STAGES = WIDE_W / DIV_BITS;
   localparam int RES_STAGES  = (RES_W + DIV_BITS - 1) / DIV_BITS;
   localparam int AB_W        = RES_STAGES * DIV_BITS;

   // Stages after the remainder pipeline: operate, partial products, two sums,
   // quotient times modulus, correction.
   localparam int TAIL_STAGES = 6;
   localparam int PIPE_DEPTH  = 1 + WIDE_STAGES + TAIL_STAGES;

   // Operation codes.
   localparam logic [CMD_W-1:0] CMD_ADD    = 3'd0;
   localparam logic [CMD_W-1:0] CMD_SUB    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_MUL    = 3'd2;
   localparam logic [CMD_W-1:0] CMD_NEG    = 3'd3;
   localparam logic [CMD_W-1:0] CMD_INC    = 3'd4;
   localparam logic [CMD_W-1:0] CMD_DEC    = 3'd5;
   localparam logic [CMD_W-1:0] CMD_REDUCE = 3'd6;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_MODULUS    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_RECIPROCAL = 1'b1;

   // Register values after reset.
   localparam logic [RES_W-1:0]   MODULUS_RESET    = 31'd998244353;
   localparam logic [RECIP_W-1:0] RECIPROCAL_RESET = 64'd18479187003;

   typedef logic [RES_W-1:0] res_type;
   typedef logic [CMD_W-1:0] cmd_type;

   typedef struct packed {
      res_type             modulus;
      logic [RECIP_W-1:0]  reciprocal;
   } cfg_type;

   typedef struct packed {
      cmd_type cmd;
      logic    neg;
      res_type a_rem;
      res_type b_rem;
      res_type w_rem;
   } rem_out_type;

endpackage

`default_nettype wire

[rtl/mab_if.sv]
`default_nettype none

// Request channel: one operation per transaction.
interface mab_req_if
   import mab_pkg::*;
();
   logic                     valid;
   logic                     ready;
   cmd_type                  cmd;
   res_type                  operand_a;
   res_type                  operand_b;
   logic signed [WIDE_W-1:0] wide_value;

   modport source (output valid, cmd, operand_a, operand_b, wide_value, input ready);
   modport sink   (input valid, cmd, operand_a, operand_b, wide_value, output ready);
endinterface

// Response channel: one residue per transaction.
interface mab_rsp_if
   import mab_pkg::*;
();
   logic    valid;
   logic    ready;
   res_type result;

   modport source (output valid, result, input ready);
   modport sink   (input valid, result, output ready);
endinterface

// Register write channel.
interface mab_csr_if
   import mab_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/mab_pipe_ctrl.sv]
`default_nettype none

module mab_pipe_ctrl
   import mab_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output logic [PIPE_DEPTH-1:0]      adv
);

   logic [PIPE_DEPTH-1:0] vld_ff;
   logic [PIPE_DEPTH-1:0] vld_in;

   // A stage may load when it is empty or when its content moves on.
   always_comb begin
      adv[PIPE_DEPTH-1] = ~vld_ff[PIPE_DEPTH-1] | out_ready;
      for (int k = PIPE_DEPTH - 2; k >= 0; k--) begin
         adv[k] = ~vld_ff[k] | adv[k+1];
      end
   end

   // Valid bits follow the data; a stage that cannot load keeps its bit.
   always_comb begin
      vld_in[0] = adv[0] ? in_valid : vld_ff[0];
      for (int k = 1; k < PIPE_DEPTH; k++) begin
         vld_in[k] = adv[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign in_ready  = adv[0];
   assign out_valid = vld_ff[PIPE_DEPTH-1];

endmodule

`default_nettype wire

[rtl/mab_rem_stage.sv]
`default_nettype none

module mab_rem_stage
   import mab_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                load,
   input  wire res_type             modulus,
   input  wire res_type             rem_i,
   input  wire logic [DIV_BITS-1:0] bits_i,
   output res_type                  rem_o
);

   logic [RES_W:0] trial;
   res_type        rem_in;
   res_type        rem_ff;

   // Restoring long division: shift in one dividend bit, subtract when it fits.
   always_comb begin
      rem_in = rem_i;
      trial  = '0;
      for (int i = DIV_BITS - 1; i >= 0; i--) begin
         trial = {rem_in, bits_i[i]};
         if (trial >= {1'b0, modulus}) begin
            trial = trial - {1'b0, modulus};
         end
         rem_in = trial[RES_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rem_ff <= rem_in;
      end
   end

   assign rem_o = rem_ff;

endmodule

`default_nettype wire

[rtl/mab_rem_pipe.sv]
`default_nettype none

module mab_rem_pipe
   import mab_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic [WIDE_STAGES:0]     adv,
   input  wire res_type                  modulus,
   input  wire cmd_type                  in_cmd,
   input  wire res_type                  in_a,
   input  wire res_type                  in_b,
   input  wire logic signed [WIDE_W-1:0] in_wide,
   output rem_out_type                   rem
);

   // First stage in which the short operands start their division.
   localparam int AB_FIRST = WIDE_STAGES - RES_STAGES + 1;

   cmd_type           cmd_ff [0:WIDE_STAGES];
   logic              neg_ff [0:WIDE_STAGES];
   res_type           a_ff   [0:WIDE_STAGES-1];
   res_type           b_ff   [0:WIDE_STAGES-1];
   logic [WIDE_W-1:0] mag_ff [0:WIDE_STAGES-1];

   res_type w_rem [0:WIDE_STAGES];
   res_type a_rem [AB_FIRST-1:WIDE_STAGES];
   res_type b_rem [AB_FIRST-1:WIDE_STAGES];

   logic              neg_in;
   logic [WIDE_W-1:0] mag_in;

   // Reduce works on the magnitude; the sign is fixed up after division.
   assign neg_in = in_wide[WIDE_W-1];
   assign mag_in = neg_in ? ('0 - $unsigned(in_wide)) : $unsigned(in_wide);

   // Input register and the operand carry along the division stages.
   always_ff @(posedge clock) begin
      if (adv[0]) begin
         cmd_ff[0] <= in_cmd;
         neg_ff[0] <= neg_in;
         a_ff[0]   <= in_a;
         b_ff[0]   <= in_b;
         mag_ff[0] <= mag_in;
      end
      for (int k = 1; k <= WIDE_STAGES; k++) begin
         if (adv[k]) begin
            cmd_ff[k] <= cmd_ff[k-1];
            neg_ff[k] <= neg_ff[k-1];
         end
      end
      for (int k = 1; k < WIDE_STAGES; k++) begin
         if (adv[k]) begin
            a_ff[k]   <= a_ff[k-1];
            b_ff[k]   <= b_ff[k-1];
            mag_ff[k] <= mag_ff[k-1];
         end
      end
   end

   assign w_rem[0]          = '0;
   assign a_rem[AB_FIRST-1] = '0;
   assign b_rem[AB_FIRST-1] = '0;

   // One division step group per stage; the short operands use only the last stages.
   genvar k;
   for (k = 1; k <= WIDE_STAGES; k++) begin : g_stage
      mab_rem_stage u_wide (
         .clock   (clock),
         .load    (adv[k]),
         .modulus (modulus),
         .rem_i   (w_rem[k-1]),
         .bits_i  (mag_ff[k-1][WIDE_W-1-DIV_BITS*(k-1) -: DIV_BITS]),
         .rem_o   (w_rem[k])
      );

      if (k >= AB_FIRST) begin : g_ab
         logic [AB_W-1:0] a_ext;
         logic [AB_W-1:0] b_ext;

         assign a_ext = AB_W'(a_ff[k-1]);
         assign b_ext = AB_W'(b_ff[k-1]);

         mab_rem_stage u_a (
            .clock   (clock),
            .load    (adv[k]),
            .modulus (modulus),
            .rem_i   (a_rem[k-1]),
            .bits_i  (a_ext[AB_W-1-DIV_BITS*(k-AB_FIRST) -: DIV_BITS]),
            .rem_o   (a_rem[k])
         );

         mab_rem_stage u_b (
            .clock   (clock),
            .load    (adv[k]),
            .modulus (modulus),
            .rem_i   (b_rem[k-1]),
            .bits_i  (b_ext[AB_W-1-DIV_BITS*(k-AB_FIRST) -: DIV_BITS]),
            .rem_o   (b_rem[k])
         );
      end
   end

   assign rem.cmd   = cmd_ff[WIDE_STAGES];
   assign rem.neg   = neg_ff[WIDE_STAGES];
   assign rem.a_rem = a_rem[WIDE_STAGES];
   assign rem.b_rem = b_rem[WIDE_STAGES];
   assign rem.w_rem = w_rem[WIDE_STAGES];

endmodule

`default_nettype wire

[rtl/mab_mul_tail.sv]
`default_nettype none

module mab_mul_tail
   import mab_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic [TAIL_STAGES-1:0] adv,
   input  wire cfg_type                cfg,
   input  wire rem_out_type            rem,
   output res_type                     result
);

   // Stage positions within this part of the pipeline.
   localparam int T_OP  = 0;
   localparam int T_PP  = 1;
   localparam int T_SUM = 2;
   localparam int T_X   = 3;
   localparam int T_XM  = 4;
   localparam int T_OUT = 5;

   res_type        m;
   logic [RES_W:0] m_ext;

   // Operate stage.
   logic [RES_W:0]    sum_add;
   logic [RES_W:0]    sum_sub;
   logic [RES_W:0]    sum_inc;
   res_type           add_r;
   res_type           sub_r;
   res_type           neg_r;
   res_type           inc_r;
   res_type           dec_r;
   res_type           red_r;
   res_type           other_in;
   logic              sel_in;
   logic [PROD_W-1:0] z_in;
   logic [PROD_W-1:0] z_ff;

   // Carried alongside the multiply path.
   res_type           other_ff [T_OP:T_XM];
   logic              sel_ff   [T_OP:T_XM];
   logic [WORD_W-1:0] zlo_ff   [T_PP:T_XM];

   // Partial product stage.
   logic [WORD_W-1:0]      z_lo;
   logic [ZH_W-1:0]        z_hi;
   logic [WORD_W-1:0]      r_lo;
   logic [WORD_W-1:0]      r_hi;
   logic [2*WORD_W-1:0]    ll_in;
   logic [2*WORD_W-1:0]    lh_in;
   logic [ZH_W+WORD_W-1:0] hl_in;
   logic [WORD_W-1:0]      hh_lo_in;
   logic [WORD_W-1:0]      ll_hi_ff;
   logic [2*WORD_W-1:0]    lh_ff;
   logic [ZH_W+WORD_W-1:0] hl_ff;
   logic [WORD_W-1:0]      hh_lo_ff;

   // Sum stages.
   logic [WORD_W+1:0] mid_in;
   logic [WORD_W-1:0] s_in;
   logic [1:0]        mid_hi_ff;
   logic [WORD_W-1:0] s_ff;
   logic [WORD_W-1:0] x_in;
   logic [WORD_W-1:0] x_ff;

   // Quotient times modulus and correction.
   logic [WORD_W-1:0] xm_in;
   logic [WORD_W-1:0] xm_ff;
   logic [WORD_W-1:0] v_raw;
   logic [WORD_W-1:0] v_fix;
   res_type           result_in;
   res_type           result_ff;

   assign m     = cfg.modulus;
   assign m_ext = {1'b0, m};

   // Residue operations other than multiply, and the product a*b.
   always_comb begin
      sum_add = {1'b0, rem.a_rem} + {1'b0, rem.b_rem};
      add_r   = (sum_add >= m_ext) ? RES_W'(sum_add - m_ext) : RES_W'(sum_add);
      sum_sub = {1'b0, rem.a_rem} + m_ext - {1'b0, rem.b_rem};
      sub_r   = (sum_sub >= m_ext) ? RES_W'(sum_sub - m_ext) : RES_W'(sum_sub);
      neg_r   = (rem.a_rem == '0) ? '0 : m - rem.a_rem;
      sum_inc = {1'b0, rem.a_rem} + (RES_W+1)'(1);
      inc_r   = (sum_inc == m_ext) ? '0 : RES_W'(sum_inc);
      dec_r   = (rem.a_rem == '0) ? m - RES_W'(1) : rem.a_rem - RES_W'(1);
      red_r   = (rem.neg && rem.w_rem != '0) ? m - rem.w_rem : rem.w_rem;

      case (rem.cmd)
         CMD_ADD:    other_in = add_r;
         CMD_SUB:    other_in = sub_r;
         CMD_MUL:    other_in = '0;
         CMD_NEG:    other_in = neg_r;
         CMD_INC:    other_in = inc_r;
         CMD_DEC:    other_in = dec_r;
         CMD_REDUCE: other_in = red_r;
         default:    other_in = '0;
      endcase

      // A zero modulus gives zero for every operation.
      if (m == '0) begin
         other_in = '0;
      end
      sel_in = (rem.cmd == CMD_MUL) && (m != '0);
   end

   assign z_in = PROD_W'(rem.a_rem) * PROD_W'(rem.b_rem);

   // Four partial products of z times the reciprocal; only what the
   // high word's low half needs is kept.
   assign z_lo     = z_ff[WORD_W-1:0];
   assign z_hi     = z_ff[PROD_W-1:WORD_W];
   assign r_lo     = cfg.reciprocal[WORD_W-1:0];
   assign r_hi     = cfg.reciprocal[RECIP_W-1:WORD_W];
   assign ll_in    = (2*WORD_W)'(z_lo) * (2*WORD_W)'(r_lo);
   assign lh_in    = (2*WORD_W)'(z_lo) * (2*WORD_W)'(r_hi);
   assign hl_in    = (ZH_W+WORD_W)'(z_hi) * (ZH_W+WORD_W)'(r_lo);
   assign hh_lo_in = WORD_W'(z_hi) * r_hi;

   // Middle column carry and the upper column sum.
   assign mid_in = (WORD_W+2)'(ll_hi_ff) + (WORD_W+2)'(lh_ff[WORD_W-1:0])
                 + (WORD_W+2)'(hl_ff[WORD_W-1:0]);
   assign s_in   = hh_lo_ff + lh_ff[2*WORD_W-1:WORD_W]
                 + WORD_W'(hl_ff[ZH_W+WORD_W-1:WORD_W]);

   // Low word of the quotient estimate.
   assign x_in = s_ff + WORD_W'(mid_hi_ff);

   // Only the low word of the quotient times modulus matters.
   assign xm_in = x_ff * WORD_W'(m);

   // Remainder estimate with one conditional correction.
   assign v_raw     = zlo_ff[T_XM] - xm_ff;
   assign v_fix     = (WORD_W'(m) <= v_raw) ? v_raw + WORD_W'(m) : v_raw;
   assign result_in = sel_ff[T_XM] ? v_fix[RES_W-1:0] : other_ff[T_XM];

   always_ff @(posedge clock) begin
      if (adv[T_OP]) begin
         z_ff           <= z_in;
         other_ff[T_OP] <= other_in;
         sel_ff[T_OP]   <= sel_in;
      end
      if (adv[T_PP]) begin
         ll_hi_ff     <= ll_in[2*WORD_W-1:WORD_W];
         lh_ff        <= lh_in;
         hl_ff        <= hl_in;
         hh_lo_ff     <= hh_lo_in;
         zlo_ff[T_PP] <= z_lo;
      end
      for (int t = T_PP; t <= T_XM; t++) begin
         if (adv[t]) begin
            other_ff[t] <= other_ff[t-1];
            sel_ff[t]   <= sel_ff[t-1];
         end
      end
      for (int t = T_SUM; t <= T_XM; t++) begin
         if (adv[t]) begin
            zlo_ff[t] <= zlo_ff[t-1];
         end
      end
      if (adv[T_SUM]) begin
         mid_hi_ff <= mid_in[WORD_W+1:WORD_W];
         s_ff      <= s_in;
      end
      if (adv[T_X]) begin
         x_ff <= x_in;
      end
      if (adv[T_XM]) begin
         xm_ff <= xm_in;
      end
      if (adv[T_OUT]) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

`default_nettype wire

[rtl/modular_arith_barrett_unit_top.sv]
// Channel   Direction  Payload                                        Handshake
// req_if    in         cmd, operand_a, operand_b, wide_value          valid/ready
// rsp_if    out        result                                         valid/ready
// csr_if    in         index (0 modulus, 1 reciprocal), data          valid/ready
//
// One transaction per cycle is accepted until a stall on rsp_if fills the pipeline;
// each result passes the input register, the 64-bit remainder pipeline (8 stages
// of 8 division steps) and six multiply and correction stages.
// Reset (synchronous) empties the pipeline and loads the register defaults.
// A stall on rsp_if holds only the stages that are full; empty stages keep
// filling, so requests are still taken while a result waits.
// csr_if is always ready.
`default_nettype none

module modular_arith_barrett_unit_top
   import mab_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   mab_req_if.sink    req_if,
   mab_rsp_if.source  rsp_if,
   mab_csr_if.sink    csr_if
);

   res_type               modulus_ff;
   logic [RECIP_W-1:0]    reciprocal_ff;
   cfg_type               cfg;
   logic [PIPE_DEPTH-1:0] adv;
   rem_out_type           rem;
   res_type               result;

   // Configuration registers.
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff    <= MODULUS_RESET;
         reciprocal_ff <= RECIPROCAL_RESET;
      end else if (csr_if.valid) begin
         case (csr_if.index)
            CSR_MODULUS:    modulus_ff    <= csr_if.data[RES_W-1:0];
            CSR_RECIPROCAL: reciprocal_ff <= csr_if.data;
            default: ;
         endcase
      end
   end

   assign cfg.modulus    = modulus_ff;
   assign cfg.reciprocal = reciprocal_ff;

   // Per-stage valid bits and load enables.
   mab_pipe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_if.valid),
      .in_ready  (req_if.ready),
      .out_valid (rsp_if.valid),
      .out_ready (rsp_if.ready),
      .adv       (adv)
   );

   // Operand reduction and wide value remainder.
   mab_rem_pipe u_rem (
      .clock   (clock),
      .adv     (adv[WIDE_STAGES:0]),
      .modulus (modulus_ff),
      .in_cmd  (req_if.cmd),
      .in_a    (req_if.operand_a),
      .in_b    (req_if.operand_b),
      .in_wide (req_if.wide_value),
      .rem     (rem)
   );

   // Residue operations and Barrett multiply.
   mab_mul_tail u_tail (
      .clock  (clock),
      .adv    (adv[PIPE_DEPTH-1:WIDE_STAGES+1]),
      .cfg    (cfg),
      .rem    (rem),
      .result (result)
   );

   assign rsp_if.result = result;

endmodule

`default_nettype wire

[rtl/mab_checker.sv]
`default_nettype none

`include "modular_arith_barrett_unit_top_assert.svh"

module mab_checker
   import mab_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_ready,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire res_type rsp_result
);

   localparam int OCC_W = $clog2(PIPE_DEPTH + 1) + 1;

   logic [OCC_W-1:0] occ_ff;
   logic [OCC_W-1:0] occ_in;

   // Transactions accepted but not yet delivered.
   assign occ_in = occ_ff + OCC_W'(req_valid && req_ready) - OCC_W'(rsp_valid && rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   `MAB_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_result), "response changed while stalled")
   `MAB_ASSERT_ALWAYS(a_occ_bound, occ_ff <= OCC_W'(PIPE_DEPTH), "more transactions in flight than stages")
   `MAB_ASSERT_IMPL(a_no_phantom, rsp_valid, occ_ff != '0, "response without an outstanding request")
   `MAB_ASSERT_IMPL(a_ready_path, !rsp_valid || rsp_ready, req_ready, "request refused with a free output")

endmodule

bind modular_arith_barrett_unit_top mab_checker u_mab_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_if.valid),
   .req_ready  (req_if.ready),
   .rsp_valid  (rsp_if.valid),
   .rsp_ready  (rsp_if.ready),
   .rsp_result (rsp_if.result)
);

`default_nettype wire

[tb/sv/mab_residue_checker.sv]
// Watches the request, response and register channels of the modular arithmetic
// unit, predicts the residue of every accepted request and compares it with the
// responses in order.
module mab_residue_checker
   import mab_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   mab_req_if        req_if,
   mab_rsp_if        rsp_if,
   mab_csr_if        csr_if,
   output int        failures
);

   localparam logic [63:0] LOW_WORD = 64'h0000_0000_FFFF_FFFF;

   res_type            modulus_q;
   logic [RECIP_W-1:0] reciprocal_q;
   res_type            expected_residues[$];
   int                 mismatches = 0;

   // Residue the unit must return for one request under the current registers.
   function automatic res_type expected_residue(input cmd_type op, input res_type opa,
                                                input res_type opb, input logic [63:0] wide);
      logic [63:0]  m;
      logic [63:0]  a;
      logic [63:0]  b;
      logic [63:0]  r;
      logic [63:0]  z;
      logic [63:0]  x;
      logic [63:0]  mag;
      logic [127:0] prod;
      m = {33'd0, modulus_q};
      // A zero modulus forces every result to zero.
      if (m == 64'd0) return '0;
      // Operands at or above the modulus are folded back first.
      a = {33'd0, opa} % m;
      b = {33'd0, opb} % m;
      r = 64'd0;
      case (op)
         CMD_ADD: begin
            r = a + b;
            if (r >= m) r = r - m;
         end
         CMD_SUB: begin
            r = a + m - b;
            if (r >= m) r = r - m;
         end
         CMD_MUL: begin
            // Quotient estimate from the upper half of the product with the
            // reciprocal, then one conditional correction on the low word.
            z = a * b;
            prod = {64'd0, z} * {64'd0, reciprocal_q};
            x = prod[127:64];
            r = (z - x * m) & LOW_WORD;
            if (m <= r) r = (r + m) & LOW_WORD;
         end
         CMD_NEG: begin
            r = m - a;
            if (r >= m) r = r - m;
         end
         CMD_INC: begin
            r = a + 64'd1;
            if (r == m) r = 64'd0;
         end
         CMD_DEC: begin
            r = (a == 64'd0) ? m - 64'd1 : a - 64'd1;
         end
         CMD_REDUCE: begin
            // Floored remainder of a two's complement value.
            if (!wide[63]) begin
               r = wide % m;
            end else begin
               mag = 64'd0 - wide;
               r = mag % m;
               if (r != 64'd0) r = m - r;
            end
         end
         default: r = 64'd0;
      endcase
      return r[RES_W-1:0];
   endfunction

   // Track the registers, queue predictions and check every response transaction.
   always @(posedge clock) begin
      res_type want;
      if (reset) begin
         modulus_q    = MODULUS_RESET;
         reciprocal_q = RECIPROCAL_RESET;
         expected_residues.delete();
      end else begin
         if (req_if.valid && req_if.ready) begin
            expected_residues.push_back(expected_residue(req_if.cmd, req_if.operand_a,
                                                         req_if.operand_b, req_if.wide_value));
         end
         if (csr_if.valid && csr_if.ready) begin
            if (csr_if.index == CSR_MODULUS) begin
               modulus_q = csr_if.data[RES_W-1:0];
            end else if (csr_if.index == CSR_RECIPROCAL) begin
               reciprocal_q = csr_if.data;
            end
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_residues.size() == 0) begin
               mismatches++;
               $display("%0t: result with nothing outstanding, expected none, actual %0d",
                        $time, rsp_if.result);
            end else begin
               want = expected_residues.pop_front();
               if (rsp_if.result !== want) begin
                  mismatches++;
                  $display("%0t: result mismatch, expected %0d, actual %0d",
                           $time, want, rsp_if.result);
               end
            end
         end
      end
      // Predictions still waiting count as failures when the run ends.
      failures <= mismatches + expected_residues.size();
   end

endmodule

[tb/sv/tb_modular_arith_barrett_unit_top.sv]
// Drives requests and register writes into the modular arithmetic unit, stalls
// the response side at random and reports the verdict from the checker.
module tb_modular_arith_barrett_unit_top;
   import mab_pkg::*;

   localparam cmd_type CMD_UNASSIGNED = 3'd7;
   localparam int QUIET_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = PIPE_DEPTH + 5;
   localparam logic [63:0] ALL_ONES = '1;
   localparam logic [63:0] WIDE_MIN = 64'h8000_0000_0000_0000;
   localparam logic [63:0] WIDE_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

   logic clock;
   logic reset;
   int   sent_count   = 0;
   int   result_count = 0;
   int   quiet_cycles = 0;
   int   failures;
   bit   calm = 1'b0;

   mab_req_if req_if();
   mab_rsp_if rsp_if();
   mab_csr_if csr_if();

   modular_arith_barrett_unit_top DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   mab_residue_checker u_residue_checker (
      .clock    (clock),
      .reset    (reset),
      .req_if   (req_if),
      .rsp_if   (rsp_if),
      .csr_if   (csr_if),
      .failures (failures)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Count response transactions so the stimulus knows when the unit is empty.
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) result_count <= result_count + 1;
   end

   // Watchdog: too long without any transaction ends the run.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("** modular_arith_barrett_unit_top: FAILED **");
         $finish;
      end
   end

   // Response side: before each result, hold ready low for a random number of cycles.
   initial begin
      int stall;
      rsp_if.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = calm ? 0 : $urandom_range(0, 4);
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_if.valid) @(posedge clock);
      end
   end

   // Send one request after a random gap and wait for its acceptance.
   task automatic send_op(input cmd_type op, input res_type opa, input res_type opb,
                          input logic [63:0] wide);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.cmd        <= op;
      req_if.operand_a  <= opa;
      req_if.operand_b  <= opb;
      req_if.wide_value <= wide;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sent_count++;
   endtask

   // Stop sending and wait until every result has come back.
   task automatic drain();
      req_if.valid <= 1'b0;
      while (result_count != sent_count) @(posedge clock);
   endtask

   // One register write transaction; valid is left high for a following write.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [63:0] data);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= data;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
   endtask

   // Write both registers in random order; upper modulus data bits are junk.
   task automatic set_modulus(input res_type m, input logic [63:0] recip);
      logic [63:0] data;
      data = {$urandom, $urandom};
      data[RES_W-1:0] = m;
      if ($urandom_range(0, 1)) begin
         write_reg(CSR_MODULUS, data);
         write_reg(CSR_RECIPROCAL, recip);
      end else begin
         write_reg(CSR_RECIPROCAL, recip);
         write_reg(CSR_MODULUS, data);
      end
      csr_if.valid <= 1'b0;
   endtask

   // Matching Barrett factor, wrapped to 64 bits; the modulus must be nonzero.
   function automatic logic [63:0] barrett_factor(input res_type m);
      return ALL_ONES / {33'd0, m} + 64'd1;
   endfunction

   // Mostly proper residues, with the edges and unreduced values mixed in.
   function automatic res_type random_residue(input res_type m);
      case ($urandom_range(0, 9))
         0: return '0;
         1: return (m == 0) ? '1 : m - 1;
         2: return res_type'($urandom);
         3: return '1;
         default: return (m == 0) ? res_type'($urandom) : res_type'($urandom_range(0, m - 1));
      endcase
   endfunction

   // Wide values: extremes, exact multiples of the modulus and their neighbors.
   function automatic logic [63:0] random_wide(input res_type m);
      logic [63:0] multiple;
      multiple = {32'd0, $urandom} * {33'd0, m};
      case ($urandom_range(0, 7))
         0: return $urandom_range(0, 1) ? WIDE_MIN : WIDE_MAX;
         1: return $urandom_range(0, 1) ? 64'd0 : ALL_ONES;
         2: return multiple + 64'($urandom_range(0, 2));
         3: return 64'd0 - multiple - 64'($urandom_range(0, 2));
         4: return $urandom_range(0, 1) ? 64'($urandom) : 64'd0 - 64'($urandom);
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Random requests; every so often switch between random gaps and stalls and full rate.
   task automatic run_random(input int count, input res_type m);
      cmd_type op;
      for (int i = 0; i < count; i++) begin
         if (i % 64 == 0) calm <= ($urandom_range(0, 3) == 0);
         op = ($urandom_range(0, 31) == 0) ? CMD_UNASSIGNED : cmd_type'($urandom_range(0, 6));
         send_op(op, random_residue(m), random_residue(m), random_wide(m));
      end
   endtask

   initial begin
      res_type m;
      reset             = 1'b1;
      req_if.valid      = 1'b0;
      req_if.cmd        = CMD_ADD;
      req_if.operand_a  = '0;
      req_if.operand_b  = '0;
      req_if.wide_value = '0;
      csr_if.valid      = 1'b0;
      csr_if.index      = CSR_MODULUS;
      csr_if.data       = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed requests under the reset modulus.
      m = MODULUS_RESET;
      send_op(CMD_ADD, m - 1, m - 1, 64'd0);
      send_op(CMD_ADD, '0, '0, ALL_ONES);
      send_op(CMD_SUB, '0, m - 1, 64'd0);
      send_op(CMD_SUB, m - 1, '0, 64'd0);
      send_op(CMD_MUL, m - 1, m - 1, 64'd0);
      send_op(CMD_MUL, '0, m - 1, 64'd0);
      send_op(CMD_MUL, 31'd12345, 31'd67890, 64'd0);
      send_op(CMD_NEG, '0, '1, 64'd0);
      send_op(CMD_NEG, m - 1, '0, WIDE_MIN);
      send_op(CMD_INC, m - 1, '1, ALL_ONES);
      send_op(CMD_INC, '0, '0, 64'd0);
      send_op(CMD_DEC, '0, '0, 64'd0);
      send_op(CMD_DEC, m - 1, '1, WIDE_MAX);
      send_op(CMD_REDUCE, '1, '1, WIDE_MIN);
      send_op(CMD_REDUCE, '0, '0, WIDE_MAX);
      send_op(CMD_REDUCE, '0, '0, 64'd0);
      send_op(CMD_REDUCE, '0, '0, ALL_ONES);
      send_op(CMD_REDUCE, '0, '0, 64'd0 - 64'(m));
      send_op(CMD_REDUCE, '0, '0, 64'(m) * 64'd7);
      send_op(CMD_UNASSIGNED, m - 1, m - 1, ALL_ONES);
      // Operands at or above the modulus.
      send_op(CMD_ADD, '1, '1, 64'd0);
      send_op(CMD_MUL, '1, '1, 64'd0);
      send_op(CMD_NEG, m, '0, 64'd0);
      send_op(CMD_DEC, m, '0, 64'd0);
      run_random(300, m);

      // Smallest nonzero modulus; its factor wraps to zero.
      drain();
      m = 31'd1;
      set_modulus(m, barrett_factor(m));
      run_random(150, m);

      // Largest modulus.
      drain();
      m = '1;
      set_modulus(m, barrett_factor(m));
      run_random(250, m);

      drain();
      m = 31'd2;
      set_modulus(m, barrett_factor(m));
      run_random(150, m);

      // Zero modulus forces every result to zero.
      drain();
      m = '0;
      set_modulus(m, {$urandom, $urandom});
      run_random(100, m);

      drain();
      m = res_type'($urandom_range(3, 65535));
      set_modulus(m, barrett_factor(m));
      run_random(200, m);

      drain();
      m = res_type'($urandom_range(32'h4000_0000, 32'h7FFF_FFFF));
      set_modulus(m, barrett_factor(m));
      run_random(250, m);

      // Reciprocal that does not match the modulus.
      drain();
      m = res_type'($urandom_range(1, 32'h7FFF_FFFF));
      set_modulus(m, {$urandom, $urandom});
      run_random(200, m);

      // Back to the reset values, written explicitly.
      drain();
      m = MODULUS_RESET;
      set_modulus(m, RECIPROCAL_RESET);
      run_random(150, m);

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("** modular_arith_barrett_unit_top: PASSED **");
      end else begin
         $display("** modular_arith_barrett_unit_top: FAILED **");
      end
      $finish;
   end

endmodule

[sim.f]
+incdir+rtl
rtl/mab_pkg.sv
rtl/mab_if.sv
rtl/mab_pipe_ctrl.sv
rtl/mab_rem_stage.sv
rtl/mab_rem_pipe.sv
rtl/mab_mul_tail.sv
rtl/modular_arith_barrett_unit_top.sv
rtl/mab_checker.sv
tb/sv/mab_residue_checker.sv
tb/sv/tb_modular_arith_barrett_unit_top.sv
